>>> rtl/fgu_pkg.sv
// ----------------------------------------------------------------------------
// fgu_pkg
// Types and constants shared by the fire effect heat grid core and its testbench.
// ----------------------------------------------------------------------------
package fgu_pkg;

  localparam int GRID_WIDTH = 64;
  localparam int GRID_ROWS  = 66;

  localparam int CELL_W = 8;
  localparam int ROW_W  = 7;
  localparam int COL_W  = 6;
  localparam int FUNC_W = 2;
  localparam int DECAY_W = 3;

  // Two cells share one RAM word; even rows and odd rows live in separate banks.
  localparam int PAIR_W     = 2 * CELL_W;
  localparam int WORDS      = (GRID_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (GRID_ROWS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * WORDS;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);
  localparam int FULL_W     = ROW_W + COL_W;

  // Sum of five cells, and sum / 5 as a multiply by a reciprocal.
  localparam int SUM_W      = $clog2(5 * ((1 << CELL_W) - 1) + 1);
  localparam int DIV5_MUL   = 3277;
  localparam int DIV5_SHIFT = 14;
  localparam int MUL_W      = SUM_W + $clog2(DIV5_MUL + 1);

  localparam logic [FUNC_W-1:0] FUNC_SEED   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CELL_W-1:0]  seed_value;
    logic [DECAY_W-1:0] decay;
    logic [ROW_W-1:0]   read_row;
    logic [COL_W-1:0]   read_col;
  } item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic              frame_done;
  } result_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [FULL_W-1:0] a;
    a = FULL_W'(row >> 1) * FULL_W'(WORDS) + FULL_W'(col >> 1);
    return a[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/fire_effect_grid_update_core.sv
// ----------------------------------------------------------------------------
// fire_effect_grid_update_core
// Heat grid of the classic fire effect: seed, in-place update and read words.
// ----------------------------------------------------------------------------
// Takes one word per clock while item_stall is low and returns one result
// word per item, in order. The grid sits in two RAM banks (even and odd
// rows, two cells per RAM word), so the five cells of an update come from four
// reads in the same cycle. A word that needs a cell still being written by
// the word just ahead of it is held by item_stall; a normal raster pass of
// updates never is. After reset the grid is cleared one word per bank per cycle,
// through all BANK_DEPTH words (1056 for a 64 x 66 grid), with item_stall held high.
module fire_effect_grid_update_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  fgu_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fgu_pkg::result_t result
);

  localparam int CW = fgu_pkg::CELL_W;
  localparam int RW = fgu_pkg::ROW_W;
  localparam int KW = fgu_pkg::COL_W;
  localparam int AW = fgu_pkg::ADDR_W;
  localparam int PW = fgu_pkg::PAIR_W;

  function automatic logic [CW-1:0] lane_of(input logic [PW-1:0] w, input logic hi);
    return hi ? w[PW-1:CW] : w[CW-1:0];
  endfunction

  // ---- clearing sweep -------------------------------------------------------
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(fgu_pkg::BANK_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---- cursors --------------------------------------------------------------
  logic [RW-1:0] urow;
  logic [KW-1:0] ucol;
  logic [KW-1:0] seed_col;
  logic          seed_hi;

  // ---- pipeline registers ---------------------------------------------------
  logic                      s1_valid;
  logic [fgu_pkg::FUNC_W-1:0] s1_func;
  logic [RW-1:0]             s1_row;
  logic [KW-1:0]             s1_col;
  logic [CW-1:0]             s1_seed;
  logic [fgu_pkg::DECAY_W-1:0] s1_decay;
  logic                      s1_done;
  logic                      s1_ok;

  logic                      s2_valid;
  logic [fgu_pkg::FUNC_W-1:0] s2_func;
  logic [RW-1:0]             s2_row;
  logic [KW-1:0]             s2_col;
  logic [fgu_pkg::SUM_W-1:0] s2_sum;
  logic [CW-1:0]             s2_val;
  logic [fgu_pkg::DECAY_W-1:0] s2_decay;
  logic                      s2_done;

  logic          fw_valid;
  logic [RW-1:0] fw_row;
  logic [KW-1:0] fw_col;
  logic [CW-1:0] fw_data;

  logic adv;
  logic accept;
  logic hazard;

  assign adv = !result_valid || !result_stall;

  // ---- incoming decode ------------------------------------------------------
  logic          in_upd, in_rd, in_seed;
  logic          rd_ok;
  logic          last_cell;
  logic [RW-1:0] seed_row;
  logic [RW-1:0] sub_row;
  logic [RW-1:0] s1_tgt_row;
  logic          s1_wr;

  assign in_upd  = item.func == fgu_pkg::FUNC_UPDATE;
  assign in_rd   = item.func == fgu_pkg::FUNC_READ;
  assign in_seed = item.func == fgu_pkg::FUNC_SEED;
  assign rd_ok   = ({1'b0, item.read_row} < (RW + 1)'(fgu_pkg::GRID_ROWS))
                && ({1'b0, item.read_col} < (KW + 1)'(fgu_pkg::GRID_WIDTH));
  assign last_cell = (ucol == KW'(fgu_pkg::GRID_WIDTH - 2))
                  && (urow == RW'(fgu_pkg::GRID_ROWS - 1));
  assign seed_row  = RW'(fgu_pkg::GRID_ROWS - 2) + RW'(seed_hi);
  assign sub_row   = in_upd ? urow : item.read_row;

  assign s1_wr      = (s1_func == fgu_pkg::FUNC_SEED) || (s1_func == fgu_pkg::FUNC_UPDATE);
  assign s1_tgt_row = (s1_func == fgu_pkg::FUNC_UPDATE) ? s1_row - RW'(1) : s1_row;

  function automatic logic hit(input logic [RW-1:0] tr, input logic [KW-1:0] tc,
                               input logic [RW-1:0] r, input logic [KW-1:0] c);
    return (tr == r) && (tc == c);
  endfunction

  always_comb begin
    hazard = 1'b0;
    if (s1_valid && s1_wr) begin
      if (in_upd) begin
        hazard = hit(s1_tgt_row, s1_col, urow, ucol - KW'(1))
              || hit(s1_tgt_row, s1_col, urow, ucol)
              || hit(s1_tgt_row, s1_col, urow, ucol + KW'(1))
              || hit(s1_tgt_row, s1_col, urow - RW'(1), ucol)
              || hit(s1_tgt_row, s1_col, urow + RW'(1), ucol);
      end else if (in_rd) begin
        hazard = hit(s1_tgt_row, s1_col, item.read_row, item.read_col);
      end
    end
  end

  assign item_stall = clr_active || !adv || hazard;
  assign accept     = item_valid && !item_stall;

  // ---- read addresses -------------------------------------------------------
  logic [AW-1:0] row_a, row_b, vert_a, vert_b;
  logic [AW-1:0] b0_ra, b0_rb, b1_ra, b1_rb;

  always_comb begin
    row_a  = fgu_pkg::word_addr(sub_row, in_upd ? ucol - KW'(1) : item.read_col);
    if (in_rd && !rd_ok) begin
      row_a = '0;
    end
    row_b  = fgu_pkg::word_addr(urow, ucol + KW'(1));
    vert_a = fgu_pkg::word_addr(urow - RW'(1), ucol);
    vert_b = (urow == RW'(fgu_pkg::GRID_ROWS - 1)) ? '0
           : fgu_pkg::word_addr(urow + RW'(1), ucol);
    b0_ra  = sub_row[0] ? vert_a : row_a;
    b0_rb  = sub_row[0] ? vert_b : row_b;
    b1_ra  = sub_row[0] ? row_a  : vert_a;
    b1_rb  = sub_row[0] ? row_b  : vert_b;
  end

  // ---- write port -----------------------------------------------------------
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_mask, wr_data;
  logic [CW-1:0] wr_val;
  logic          b0_we, b1_we;
  logic [AW-1:0] bank_waddr;
  logic [PW-1:0] bank_wmask, bank_wdata;
  logic [PW-1:0] b0_da, b0_db, b1_da, b1_db;

  assign b0_we      = clr_active || (wr_en && !s2_row[0]);
  assign b1_we      = clr_active || (wr_en && s2_row[0]);
  assign bank_waddr = clr_active ? clr_addr : wr_addr;
  assign bank_wmask = clr_active ? {PW{1'b1}} : wr_mask;
  assign bank_wdata = clr_active ? '0 : wr_data;

  fgu_ram #(.WIDTH(PW), .DEPTH(fgu_pkg::BANK_DEPTH)) u_bank_even (
    .clk       (clk),
    .wr_en     (b0_we),
    .wr_addr   (bank_waddr),
    .wr_mask   (bank_wmask),
    .wr_data   (bank_wdata),
    .rd_en     (accept),
    .rd_addr_a (b0_ra),
    .rd_addr_b (b0_rb),
    .rd_data_a (b0_da),
    .rd_data_b (b0_db)
  );

  fgu_ram #(.WIDTH(PW), .DEPTH(fgu_pkg::BANK_DEPTH)) u_bank_odd (
    .clk       (clk),
    .wr_en     (b1_we),
    .wr_addr   (bank_waddr),
    .wr_mask   (bank_wmask),
    .wr_data   (bank_wdata),
    .rd_en     (accept),
    .rd_addr_a (b1_ra),
    .rd_addr_b (b1_rb),
    .rd_data_a (b1_da),
    .rd_data_b (b1_db)
  );

  // ---- control registers ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      urow     <= RW'(1);
      ucol     <= KW'(1);
      seed_col <= '0;
      seed_hi  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      fw_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept && in_upd) begin
        if (ucol != KW'(fgu_pkg::GRID_WIDTH - 2)) begin
          ucol <= ucol + KW'(1);
        end else begin
          ucol <= KW'(1);
          urow <= last_cell ? RW'(1) : urow + RW'(1);
        end
      end
      if (accept && in_seed) begin
        if (seed_col == KW'(fgu_pkg::GRID_WIDTH - 1)) begin
          seed_col <= '0;
          seed_hi  <= !seed_hi;
        end else begin
          seed_col <= seed_col + KW'(1);
        end
      end
      if (adv) begin
        s1_valid     <= accept;
        s2_valid     <= s1_valid;
        fw_valid     <= wr_en;
        result_valid <= s2_valid;
      end
    end
  end

  // ---- stage 1: select, forward, sum ----------------------------------------
  logic [PW-1:0] wa, wb, va, vb;
  logic [CW-1:0] c_l, c_c, c_r, c_u, c_d, c_rd;
  logic [RW-1:0] s1_out_row;
  logic [CW-1:0] s1_out_val;
  logic [fgu_pkg::SUM_W-1:0] s1_sum;

  function automatic logic [CW-1:0] fwd(input logic [CW-1:0] v, input logic [RW-1:0] r,
                                        input logic [KW-1:0] c, input logic fv,
                                        input logic [RW-1:0] fr, input logic [KW-1:0] fc,
                                        input logic [CW-1:0] fd);
    return (fv && fr == r && fc == c) ? fd : v;
  endfunction

  always_comb begin
    wa = s1_row[0] ? b1_da : b0_da;
    wb = s1_row[0] ? b1_db : b0_db;
    va = s1_row[0] ? b0_da : b1_da;
    vb = s1_row[0] ? b0_db : b1_db;

    c_l = fwd(lane_of(wa, !s1_col[0]), s1_row, s1_col - KW'(1),
              fw_valid, fw_row, fw_col, fw_data);
    c_r = fwd(lane_of(wb, !s1_col[0]), s1_row, s1_col + KW'(1),
              fw_valid, fw_row, fw_col, fw_data);
    c_c = fwd(s1_col[0] ? lane_of(wa, 1'b1) : lane_of(wb, 1'b0), s1_row, s1_col,
              fw_valid, fw_row, fw_col, fw_data);
    c_u = fwd(lane_of(va, s1_col[0]), s1_row - RW'(1), s1_col,
              fw_valid, fw_row, fw_col, fw_data);
    c_d = s1_ok ? fwd(lane_of(vb, s1_col[0]), s1_row + RW'(1), s1_col,
                      fw_valid, fw_row, fw_col, fw_data) : '0;
    c_rd = s1_ok ? fwd(lane_of(wa, s1_col[0]), s1_row, s1_col,
                       fw_valid, fw_row, fw_col, fw_data) : '0;

    s1_sum = fgu_pkg::SUM_W'(c_l) + fgu_pkg::SUM_W'(c_c) + fgu_pkg::SUM_W'(c_r)
           + fgu_pkg::SUM_W'(c_u) + fgu_pkg::SUM_W'(c_d);
    s1_out_row = s1_tgt_row;
    s1_out_val = (s1_func == fgu_pkg::FUNC_SEED) ? s1_seed
               : (s1_func == fgu_pkg::FUNC_READ) ? c_rd : '0;
  end

  // ---- stage 2: divide by five, decay, write back ---------------------------
  logic [fgu_pkg::MUL_W-1:0] prod;
  logic [CW-1:0]             avg;
  logic [CW-1:0]             res_val;

  always_comb begin
    prod = fgu_pkg::MUL_W'(s2_sum) * fgu_pkg::MUL_W'(fgu_pkg::DIV5_MUL);
    avg  = prod[fgu_pkg::DIV5_SHIFT +: CW];
    if (s2_func == fgu_pkg::FUNC_UPDATE) begin
      res_val = (avg > CW'(s2_decay)) ? avg - CW'(s2_decay) : '0;
    end else begin
      res_val = s2_val;
    end
    wr_val  = res_val;
    wr_en   = adv && s2_valid
           && ((s2_func == fgu_pkg::FUNC_SEED) || (s2_func == fgu_pkg::FUNC_UPDATE));
    wr_addr = fgu_pkg::word_addr(s2_row, s2_col);
    wr_mask = {{CW{s2_col[0]}}, {CW{!s2_col[0]}}};
    wr_data = {wr_val, wr_val};
  end

  // ---- payload registers ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= item.func;
      s1_seed  <= item.seed_value;
      s1_decay <= item.decay;
      s1_done  <= in_upd && last_cell;
      unique case (item.func)
        fgu_pkg::FUNC_SEED: begin
          s1_row <= seed_row;
          s1_col <= seed_col;
          s1_ok  <= 1'b0;
        end
        fgu_pkg::FUNC_UPDATE: begin
          s1_row <= urow;
          s1_col <= ucol;
          s1_ok  <= urow != RW'(fgu_pkg::GRID_ROWS - 1);
        end
        fgu_pkg::FUNC_READ: begin
          s1_row <= item.read_row;
          s1_col <= item.read_col;
          s1_ok  <= rd_ok;
        end
        default: begin
          s1_row <= '0;
          s1_col <= '0;
          s1_ok  <= 1'b0;
        end
      endcase
    end
    if (adv) begin
      s2_func  <= s1_func;
      s2_row   <= s1_out_row;
      s2_col   <= s1_col;
      s2_sum   <= s1_sum;
      s2_val   <= s1_out_val;
      s2_decay <= s1_decay;
      s2_done  <= s1_done;
      fw_row   <= s2_row;
      fw_col   <= s2_col;
      fw_data  <= wr_val;
      result.cell_value <= res_val;
      result.cell_row   <= s2_row;
      result.cell_col   <= s2_col;
      result.frame_done <= s2_done;
    end
  end

endmodule

>>> rtl/fgu_ram.sv
// ----------------------------------------------------------------------------
// fgu_ram
// Single write port with bit mask, two registered read ports.
// ----------------------------------------------------------------------------
module fgu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1056
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_mask,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_data[i];
        end
      end
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> verif/tb_fire_effect_grid_update_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fire_effect_grid_update_core
// Self-checking bench for the fire effect heat grid core.
// ----------------------------------------------------------------------------
// Drives seed, update, read and unused-code words through the valid/stall
// handshake with random idle bursts on both sides. A behavioural copy of the
// heat grid and its cursors predicts every result word; each returned word is
// compared field by field with the oldest prediction. Covers corner values,
// back-to-back write/read hazards, a seeded bottom with an in-place update
// sweep, out-of-range reads and a random mix.
// ----------------------------------------------------------------------------
module tb_fire_effect_grid_update_core;

  localparam logic [fgu_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  fgu_pkg::item_t   item_word;
  logic             result_valid;
  logic             result_stall = 1'b0;
  fgu_pkg::result_t result_word;

  byte unsigned heat [fgu_pkg::GRID_ROWS][fgu_pkg::GRID_WIDTH];
  int      seed_pos = 0;
  int      upd_row = 1;
  int      upd_col = 1;
  int      last_row = 0;
  int      last_col = 0;

  fgu_pkg::result_t expected_cells [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      hold_left = 0;
  bit      sender_idles = 1'b0;
  bit      receiver_stalls = 1'b0;
  int      n_seed = 0;
  int      n_update = 0;
  int      n_read = 0;
  int      n_unused = 0;
  int      passes_done = 0;

  fire_effect_grid_update_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** fire_effect_grid_update_core: FAILED **");
      $finish;
    end
  end

  function automatic int heat_at(input int row, input int col);
    if (row < 0 || row >= fgu_pkg::GRID_ROWS || col < 0 || col >= fgu_pkg::GRID_WIDTH)
      return 0;
    return heat[row][col];
  endfunction

  function automatic fgu_pkg::result_t predict_cell(input fgu_pkg::item_t w);
    fgu_pkg::result_t r;
    int      y;
    int      x;
    int      sum;
    int      avg;
    r = '0;
    unique case (w.func)
      fgu_pkg::FUNC_SEED: begin
        y = (fgu_pkg::GRID_ROWS - 2) + seed_pos / fgu_pkg::GRID_WIDTH;
        x = seed_pos % fgu_pkg::GRID_WIDTH;
        heat[y][x] = w.seed_value;
        seed_pos = (seed_pos + 1) % (2 * fgu_pkg::GRID_WIDTH);
        r.cell_value = w.seed_value;
        r.cell_row = fgu_pkg::ROW_W'(y);
        r.cell_col = fgu_pkg::COL_W'(x);
        last_row = y;
        last_col = x;
        n_seed++;
      end
      fgu_pkg::FUNC_UPDATE: begin
        y = upd_row;
        x = upd_col;
        sum = heat_at(y, x) + heat_at(y - 1, x) + heat_at(y + 1, x)
            + heat_at(y, x - 1) + heat_at(y, x + 1);
        avg = sum / 5;
        avg = (avg > w.decay) ? avg - w.decay : 0;
        heat[y - 1][x] = byte'(avg);
        r.cell_value = fgu_pkg::CELL_W'(avg);
        r.cell_row = fgu_pkg::ROW_W'(y - 1);
        r.cell_col = fgu_pkg::COL_W'(x);
        if (x + 1 < fgu_pkg::GRID_WIDTH - 1) begin
          upd_col = x + 1;
        end else if (y + 1 < fgu_pkg::GRID_ROWS) begin
          upd_row = y + 1;
          upd_col = 1;
        end else begin
          upd_row = 1;
          upd_col = 1;
          r.frame_done = 1'b1;
          passes_done++;
        end
        last_row = y - 1;
        last_col = x;
        n_update++;
      end
      fgu_pkg::FUNC_READ: begin
        r.cell_value = fgu_pkg::CELL_W'(heat_at(w.read_row, w.read_col));
        r.cell_row = w.read_row;
        r.cell_col = w.read_col;
        n_read++;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Check each returned word, then decide the stall for the next cycle.
  always @(posedge clk) begin
    fgu_pkg::result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_cells.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_cells.pop_front();
        check_field("cell_value", want.cell_value, result_word.cell_value);
        check_field("cell_row", 8'(want.cell_row), 8'(result_word.cell_row));
        check_field("cell_col", 8'(want.cell_col), 8'(result_word.cell_col));
        check_field("frame_done", 8'(want.frame_done), 8'(result_word.frame_done));
      end
    end
    if (hold_left == 0 && receiver_stalls && $urandom_range(0, 7) == 0)
      hold_left = $urandom_range(1, 15);
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic fgu_pkg::item_t make_word(input logic [fgu_pkg::FUNC_W-1:0] func,
                                               input int seed, input int decay,
                                               input int row, input int col);
    fgu_pkg::item_t w;
    w.func = func;
    w.seed_value = fgu_pkg::CELL_W'(seed);
    w.decay = fgu_pkg::DECAY_W'(decay);
    w.read_row = fgu_pkg::ROW_W'(row);
    w.read_col = fgu_pkg::COL_W'(col);
    return w;
  endfunction

  function automatic fgu_pkg::item_t random_word();
    return make_word(fgu_pkg::FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 7), $urandom_range(0, 127),
                     $urandom_range(0, 63));
  endfunction

  task automatic send_word(input fgu_pkg::item_t w);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_word <= w;
    item_valid <= 1'b1;
    expected_cells.push_back(predict_cell(w));
    do @(posedge clk); while (item_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    send_word(make_word(fgu_pkg::FUNC_SEED, 255, 0, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS - 2, 0));
    send_word(make_word(fgu_pkg::FUNC_SEED, 0, 0, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_SEED, 128, 0, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS - 2, 2));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS - 2, 1));
    send_word(make_word(fgu_pkg::FUNC_SEED, 85, 7, 127, 63));
    send_word(make_word(fgu_pkg::FUNC_UPDATE, 0, 0, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, 0, 1));
    send_word(make_word(fgu_pkg::FUNC_UPDATE, 0, 5, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_UPDATE, 0, 6, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_UPDATE, 255, 7, 127, 63));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS - 1,
                        fgu_pkg::GRID_WIDTH - 1));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS, 0));
    send_word(make_word(fgu_pkg::FUNC_READ, 255, 7, 127, 63));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, 0, 0));
    send_word(make_word(FUNC_NONE, 255, 7, 127, 63));
    send_word(make_word(FUNC_NONE, 0, 0, 0, 0));
    send_word(make_word(fgu_pkg::FUNC_READ, 0, 0, fgu_pkg::GRID_ROWS - 2, 3));
  endtask

  // Seed the whole bottom, then advance the update cursor with a mix of words.
  task automatic test_update_sweep(input int count);
    fgu_pkg::item_t w;
    int    pick;
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < 2 * fgu_pkg::GRID_WIDTH; i++) begin
      w = random_word();
      w.func = fgu_pkg::FUNC_SEED;
      if (i % 4 != 0)
        w.seed_value = fgu_pkg::CELL_W'($urandom_range(160, 255));
      send_word(w);
    end
    for (int i = 0; i < count; i++) begin
      w = random_word();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        w.func = fgu_pkg::FUNC_UPDATE;
        if (pick < 70)
          w.decay = fgu_pkg::DECAY_W'($urandom_range(0, 2));
      end else if (pick < 93) begin
        w.func = fgu_pkg::FUNC_SEED;
      end else begin
        w.func = fgu_pkg::FUNC_READ;
        w.read_row = fgu_pkg::ROW_W'(last_row);
        w.read_col = fgu_pkg::COL_W'(last_col);
      end
      send_word(w);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input bit with_idling);
    fgu_pkg::item_t w;
    int    pick;
    sender_idles = with_idling;
    receiver_stalls = with_idling;
    for (int i = 0; i < count; i++) begin
      w = random_word();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        w.func = fgu_pkg::FUNC_UPDATE;
        if ($urandom_range(0, 3) != 0)
          w.decay = fgu_pkg::DECAY_W'($urandom_range(0, 5));
      end else if (pick < 65) begin
        w.func = fgu_pkg::FUNC_SEED;
      end else if (pick < 95) begin
        w.func = fgu_pkg::FUNC_READ;
        if (pick < 80) begin
          w.read_row = fgu_pkg::ROW_W'(last_row + $urandom_range(0, 2) - 1);
          w.read_col = fgu_pkg::COL_W'(last_col + $urandom_range(0, 2) - 1);
        end else if (pick < 90) begin
          w.read_row = fgu_pkg::ROW_W'($urandom_range(0, fgu_pkg::GRID_ROWS - 1));
        end
      end else begin
        w.func = FUNC_NONE;
      end
      send_word(w);
      if (i % 250 == 249)
        wait_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item_word <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_update_sweep(400);
    test_random_traffic(550, 1'b1);
    test_random_traffic(200, 1'b0);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d seed, %0d update, %0d read and %0d unused-code words,",
             n_seed, n_update, n_read, n_unused);
    $display("%0d frame wrap(s), random idling on both sides and drained pauses.",
             passes_done);
    if (mismatches == 0) begin
      $display("** fire_effect_grid_update_core: PASSED **");
    end else begin
      $display("** fire_effect_grid_update_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fgu_pkg.sv
rtl/fgu_ram.sv
rtl/fire_effect_grid_update_core.sv
verif/tb_fire_effect_grid_update_core.sv
